// File: rtl/core/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared widths, result kinds, the queue entry type and the lead-byte decode.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

   localparam int BYTE_WIDTH      = 8;
   localparam int CP_WIDTH        = 31;
   localparam int KIND_WIDTH      = 2;
   localparam int PENDING_WIDTH   = 3;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KIND_WIDTH-1:0] KIND_VALID   = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_INVALID = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_END     = 2'd2;

   localparam logic [PENDING_WIDTH-1:0] MAX_PENDING = 3'd5;

   // One accepted item's worth of results: an optional invalid result for an
   // interrupted sequence, then an optional main result.
   typedef struct packed {
      logic                  first_inv;
      logic                  has_main;
      logic [KIND_WIDTH-1:0] kind;
      logic [CP_WIDTH-1:0]   code_point;
   } entry_type;

   // Number of continuation bytes announced by a lead byte C0..FD.
   function automatic logic [PENDING_WIDTH-1:0] lead_length(input logic [BYTE_WIDTH-1:0] b);
      logic [PENDING_WIDTH-1:0] n;
      begin
         if (b[5] == 1'b0) begin
            n = 3'd1;
         end else if (b[4] == 1'b0) begin
            n = 3'd2;
         end else if (b[3] == 1'b0) begin
            n = 3'd3;
         end else if (b[2] == 1'b0) begin
            n = 3'd4;
         end else begin
            n = 3'd5;
         end
         return n;
      end
   endfunction

   // Payload bits that a lead byte seeds into the accumulator.
   function automatic logic [CP_WIDTH-1:0] lead_payload(input logic [BYTE_WIDTH-1:0] b,
                                                        input logic [PENDING_WIDTH-1:0] n);
      logic [5:0] mask;
      begin
         mask = 6'h3F >> n;
         return {{(CP_WIDTH-6){1'b0}}, b[5:0] & mask};
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/utf8d_if.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder channels
// Valid/ready channels for input bytes and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8d_req_if
   import utf8d_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] data_byte;
   logic                  stream_end;

   modport source (output valid, output data_byte, output stream_end, input ready);
   modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface utf8d_rsp_if
   import utf8d_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CP_WIDTH-1:0]   code_point;
   logic [KIND_WIDTH-1:0] kind;
   logic                  last;

   modport source (output valid, output code_point, output kind, output last, input ready);
   modport sink   (input valid, input code_point, input kind, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/utf8d_front.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts bytes, tracks the open sequence and classifies each beat.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_front
   import utf8d_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic                  csr_write_data,
   input  wire logic                  in_valid,
   output      logic                  in_ready,
   input  wire logic [BYTE_WIDTH-1:0] in_byte,
   input  wire logic                  in_end,
   input  wire logic                  queue_full,
   output      logic                  push,
   output      entry_type             push_entry
);

   logic                     decode_ff, decode_in;
   logic [PENDING_WIDTH-1:0] pending_ff, pending_in;
   logic [CP_WIDTH-1:0]      partial_ff, partial_in;

   logic                     accept;
   logic                     is_cont;
   logic                     open_seq;
   logic [CP_WIDTH-1:0]      shifted;
   logic [PENDING_WIDTH-1:0] lead_n;
   entry_type                entry;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign is_cont  = (in_byte[7:6] == 2'b10);
   assign open_seq = (pending_ff != '0);
   assign shifted  = {partial_ff[CP_WIDTH-7:0], in_byte[5:0]};
   assign lead_n   = lead_length(in_byte);

   always_comb begin
      entry      = '0;
      pending_in = pending_ff;
      partial_in = partial_ff;
      if (in_end) begin
         entry.first_inv = open_seq;
         entry.has_main  = 1'b1;
         entry.kind      = KIND_END;
         pending_in      = '0;
         partial_in      = '0;
      end else if (!decode_ff) begin
         entry.first_inv  = open_seq;
         entry.has_main   = 1'b1;
         entry.kind       = KIND_VALID;
         entry.code_point = {{(CP_WIDTH-BYTE_WIDTH){1'b0}}, in_byte};
         pending_in       = '0;
         partial_in       = '0;
      end else if (open_seq && is_cont) begin
         pending_in = pending_ff - 3'd1;
         if (pending_ff == 3'd1) begin
            entry.has_main   = 1'b1;
            entry.kind       = KIND_VALID;
            entry.code_point = shifted;
            partial_in       = '0;
         end else begin
            partial_in = shifted;
         end
      end else begin
         // A non-continuation byte closes any open sequence, then starts over.
         entry.first_inv = open_seq;
         pending_in      = '0;
         partial_in      = '0;
         if (in_byte[7] == 1'b0) begin
            entry.has_main   = 1'b1;
            entry.kind       = KIND_VALID;
            entry.code_point = {{(CP_WIDTH-BYTE_WIDTH){1'b0}}, in_byte};
         end else if (in_byte[6] == 1'b0 || in_byte[7:1] == 7'h7F) begin
            entry.has_main = 1'b1;
            entry.kind     = KIND_INVALID;
         end else begin
            pending_in = lead_n;
            partial_in = lead_payload(in_byte, lead_n);
         end
      end
   end

   assign decode_in  = csr_write_enable ? csr_write_data : decode_ff;
   assign push       = accept && (entry.first_inv || entry.has_main);
   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_ff  <= 1'b1;
         pending_ff <= '0;
         partial_ff <= '0;
      end else begin
         decode_ff <= decode_in;
         if (accept) begin
            pending_ff <= pending_in;
            partial_ff <= partial_in;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_pending_range : assert property (@(posedge clock) disable iff (reset)
      pending_ff <= MAX_PENDING)
      else $error("continuation count out of range");

   a_idle_partial_clear : assert property (@(posedge clock) disable iff (reset)
      pending_ff == '0 |-> partial_ff == '0)
      else $error("accumulator not cleared with no sequence open");
`endif

endmodule

`default_nettype wire

// File: rtl/core/utf8d_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder entry queue
// Short FIFO of classified beats between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_queue
   import utf8d_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output      logic      full,
   output      logic      not_empty,
   output      entry_type head
);

   entry_type                  slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slots_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop)
      else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

// File: rtl/core/utf8d_back.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Expands queue entries into one or two result beats in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_back
   import utf8d_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  not_empty,
   input  wire entry_type             head,
   output      logic                  pop,
   output      logic                  out_valid,
   input  wire logic                  out_ready,
   output      logic [CP_WIDTH-1:0]   out_code_point,
   output      logic [KIND_WIDTH-1:0] out_kind,
   output      logic                  out_last
);

   logic                  valid_ff, valid_in;
   logic                  second_ff, second_in;
   logic [CP_WIDTH-1:0]   cp_ff, cp_in;
   logic [KIND_WIDTH-1:0] kind_ff, kind_in;
   logic                  last_ff, last_in;
   logic                  load;
   logic                  split;

   // The output register takes a new beat whenever it is empty or being drained.
   assign load  = !valid_ff || out_ready;
   assign split = head.first_inv && head.has_main && !second_ff;

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      cp_in     = cp_ff;
      kind_in   = kind_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      if (load) begin
         valid_in = not_empty;
         if (not_empty) begin
            if (split) begin
               cp_in     = '0;
               kind_in   = KIND_INVALID;
               last_in   = 1'b0;
               second_in = 1'b1;
            end else begin
               pop       = 1'b1;
               second_in = 1'b0;
               last_in   = 1'b1;
               if (head.has_main) begin
                  cp_in   = head.code_point;
                  kind_in = head.kind;
               end else begin
                  cp_in   = '0;
                  kind_in = KIND_INVALID;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cp_ff   <= cp_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   assign out_valid      = valid_ff;
   assign out_code_point = cp_ff;
   assign out_kind       = kind_ff;
   assign out_last       = last_ff;

`ifndef NO_ASSERTIONS
   a_first_of_two_invalid : assert property (@(posedge clock) disable iff (reset)
      valid_ff && !last_ff |-> kind_ff == KIND_INVALID && cp_ff == '0)
      else $error("leading beat of a pair is not an invalid result");

   a_second_follows_split : assert property (@(posedge clock) disable iff (reset)
      second_ff |-> valid_ff && !last_ff)
      else $error("second half pending without the first beat held");
`endif

endmodule

`default_nettype wire

// File: rtl/core/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a byte stream in six-byte UTF-8 into 31-bit code points.
// ----------------------------------------------------------------------------
// The req channel carries one byte per beat, or an end-of-stream mark with
// stream_end set. The rsp channel returns code_point, kind (valid, invalid or
// end) and last, which flags the final result caused by one request beat.
// A request beat gives zero, one or two result beats; lead and middle bytes of
// a sequence give none. csr_write_enable/csr_write_data set raw mode (0) or
// decoding (1); the user must write them only while the block is idle, as the
// block does not enforce it. One request beat is accepted per cycle while the
// four-entry queue between the classifier and the output stage has room. A
// beat's first result passes through the queue, then the output register, which
// issues one result per cycle while the receiver is ready; pairs go in turn.
// Reset sets decoding mode, closes any open sequence and empties the queue
// and output register. When the receiver stalls the output register holds
// its beat, the queue fills and req.ready drops once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder
   import utf8d_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   csr_write_enable,
   input  wire logic   csr_write_data,
   utf8d_req_if.sink   req_bus,
   utf8d_rsp_if.source rsp_bus
);

   logic      queue_full;
   logic      queue_not_empty;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type head;

   utf8d_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .in_valid         (req_bus.valid),
      .in_ready         (req_bus.ready),
      .in_byte          (req_bus.data_byte),
      .in_end           (req_bus.stream_end),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   utf8d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   utf8d_back u_back (
      .clock          (clock),
      .reset          (reset),
      .not_empty      (queue_not_empty),
      .head           (head),
      .pop            (pop),
      .out_valid      (rsp_bus.valid),
      .out_ready      (rsp_bus.ready),
      .out_code_point (rsp_bus.code_point),
      .out_kind       (rsp_bus.kind),
      .out_last       (rsp_bus.last)
   );

endmodule

`default_nettype wire

// File: tb/sv/utf8d_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 decoder scoreboard
// Tracks the decoder's sequence state and mode, predicts the result beats
// for every accepted request beat and checks the returned beats in order.
// ----------------------------------------------------------------------------

package utf8d_tb_pkg;

   import utf8d_pkg::*;

   typedef struct packed {
      logic [CP_WIDTH-1:0]   code_point;
      logic [KIND_WIDTH-1:0] kind;
      logic                  last;
   } char_result_type;

   class utf8_char_scoreboard;

      bit                       decode_on = 1'b1;
      logic [PENDING_WIDTH-1:0] conts_left = '0;
      logic [CP_WIDTH-1:0]      accum = '0;
      char_result_type          beat_chars[$];
      char_result_type          expected_chars[$];
      int                       mismatches = 0;

      function void set_mode(bit decode);
         decode_on = decode;
      endfunction

      function int outstanding();
         return expected_chars.size();
      endfunction

      function void push_char(logic [CP_WIDTH-1:0] cp, logic [KIND_WIDTH-1:0] kind);
         char_result_type r;
         r.code_point = cp;
         r.kind       = kind;
         r.last       = 1'b0;
         beat_chars.push_back(r);
      endfunction

      function void close_sequence();
         conts_left = '0;
         accum      = '0;
      endfunction

      // A byte seen with no sequence open: ASCII, junk, or a lead byte.
      function void start_fresh(logic [7:0] b);
         logic [7:0]               shifted;
         logic [PENDING_WIDTH-1:0] need;
         if (b < 8'h80) begin
            push_char(CP_WIDTH'(b), KIND_VALID);
         end else if (b < 8'hC0 || b >= 8'hFE) begin
            push_char('0, KIND_INVALID);
         end else begin
            need    = 3'd1;
            shifted = b;
            while (shifted >= 8'hE0 && need < MAX_PENDING) begin
               shifted = shifted << 1;
               need    = need + 3'd1;
            end
            conts_left = need;
            accum      = CP_WIDTH'(b & (8'h3F >> need));
         end
      endfunction

      function void note_beat(logic [7:0] b, logic is_end);
         char_result_type r;
         beat_chars.delete();
         if (is_end) begin
            if (conts_left != 0) push_char('0, KIND_INVALID);
            close_sequence();
            push_char('0, KIND_END);
         end else if (!decode_on) begin
            if (conts_left != 0) push_char('0, KIND_INVALID);
            close_sequence();
            push_char(CP_WIDTH'(b), KIND_VALID);
         end else if (conts_left != 0) begin
            if (b[7:6] == 2'b10) begin
               accum      = {accum[CP_WIDTH-7:0], b[5:0]};
               conts_left = conts_left - 3'd1;
               if (conts_left == 0) begin
                  push_char(accum, KIND_VALID);
                  accum = '0;
               end
            end else begin
               // The sequence was cut short: flag it, then take the byte anew.
               push_char('0, KIND_INVALID);
               close_sequence();
               start_fresh(b);
            end
         end else begin
            start_fresh(b);
         end
         foreach (beat_chars[i]) begin
            r      = beat_chars[i];
            r.last = (i == beat_chars.size() - 1);
            expected_chars.push_back(r);
         end
      endfunction

      function void check_result(logic [CP_WIDTH-1:0] cp, logic [KIND_WIDTH-1:0] kind,
                                 logic last);
         char_result_type want;
         if (expected_chars.size() == 0) begin
            $error("unexpected result beat: code_point=%h kind=%0d last=%0d", cp, kind, last);
            mismatches++;
            return;
         end
         want = expected_chars.pop_front();
         if (cp !== want.code_point) begin
            $error("code_point mismatch: expected %h, actual %h", want.code_point, cp);
            mismatches++;
         end
         if (kind !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, last);
            mismatches++;
         end
      endfunction

   endclass

endpackage

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Drives directed and random byte streams in both modes with random stalls
// on both channels, and checks every result beat against a scoreboard.
// ----------------------------------------------------------------------------

module testbench;

   import utf8d_pkg::*;
   import utf8d_tb_pkg::*;

   localparam int STALL_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int PHASE_COUNT     = 6;
   localparam int BYTES_PER_PHASE = 250;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   utf8d_req_if req_bus ();
   utf8d_rsp_if rsp_bus ();

   utf8_char_scoreboard board;

   bit source_idle_on;
   bit sink_idle_on;
   int bytes_sent;
   int stall_cycles;
   int sink_hold;

   logic [7:0] warmup_bytes[$] = '{
      8'h00, 8'h7F, 8'h80, 8'hFF, 8'hFE,
      8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
      8'hF0, 8'h9F, 8'h98, 8'h80,
      8'hE2, 8'h41,
      8'hE2, 8'hC3, 8'hA9,
      8'hC2, 8'hFF,
      8'hF0
   };

   utf8_stream_decoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Called on a falling edge; returns on the falling edge after the beat
   // was taken, with valid still high.
   task automatic send_beat(input logic [7:0] b, input logic is_end);
      int gap;
      if (source_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.data_byte  <= b;
      req_bus.stream_end <= is_end;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // A character of n bytes; only the first keep continuation bytes are sent.
   task automatic send_sequence(input int n, input int keep);
      logic [7:0] lead;
      if (n == 1) begin
         send_beat(8'($urandom_range(0, 127)), 1'b0);
      end else begin
         lead = (8'hFF << (8 - n)) | (8'($urandom) & (8'h7F >> n));
         send_beat(lead, 1'b0);
         for (int i = 0; i < keep; i++) begin
            send_beat(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
         end
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
      // Lead bytes give no result and may still be in flight.
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(input bit decode);
      csr_write_enable <= 1'b1;
      csr_write_data   <= decode;
      @(posedge clock);
      board.set_mode(decode);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_decode_phase();
      int pick;
      int n;
      while (bytes_sent < BYTES_PER_PHASE) begin
         pick = $urandom_range(0, 99);
         n    = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(2, 6);
         if (pick < 70) begin
            send_sequence(n, n - 1);
         end else if (pick < 80) begin
            n = $urandom_range(2, 6);
            send_sequence(n, $urandom_range(0, n - 2));
         end else if (pick < 90) begin
            send_beat(8'($urandom), 1'b0);
         end else if (pick < 95) begin
            send_beat(8'($urandom), 1'b1);
         end else begin
            send_beat(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
         end
      end
   endtask

   task automatic run_raw_phase();
      while (bytes_sent < BYTES_PER_PHASE) begin
         send_beat(8'($urandom), ($urandom_range(0, 11) == 0));
      end
   endtask

   // Receiver stalls come in bursts of random length, drawn when a burst starts.
   initial begin
      rsp_bus.ready = 1'b0;
      sink_hold     = 0;
      forever begin
         @(negedge clock);
         if (sink_hold > 0) begin
            sink_hold--;
            rsp_bus.ready <= 1'b0;
         end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
            sink_hold = $urandom_range(1, 10) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         board.note_beat(req_bus.data_byte, req_bus.stream_end);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         board.check_result(rsp_bus.code_point, rsp_bus.kind, rsp_bus.last);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      board              = new();
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = 1'b0;
      req_bus.valid      = 1'b0;
      req_bus.data_byte  = '0;
      req_bus.stream_end = 1'b0;
      source_idle_on     = 1'b1;
      sink_idle_on       = 1'b1;
      bytes_sent         = 0;
      stall_cycles       = 0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: ASCII and junk extremes, the longest sequence, cut-short
      // sequences, and end of stream with and without an open sequence.
      foreach (warmup_bytes[i]) send_beat(warmup_bytes[i], 1'b0);
      send_beat(8'hFF, 1'b1);
      send_beat(8'h00, 1'b1);
      // Leave a sequence open across the switch to raw mode.
      send_beat(8'hE4, 1'b0);
      drain_results();
      write_mode(1'b0);
      send_beat(8'h80, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'hC3, 1'b1);
      drain_results();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         source_idle_on = (p != 2) && (p != PHASE_COUNT - 1);
         sink_idle_on   = (p != 3) && (p != PHASE_COUNT - 1);
         bytes_sent     = 0;
         if (p == 1 || p == 4) begin
            write_mode(1'b0);
            run_raw_phase();
         end else begin
            write_mode(1'b1);
            run_decode_phase();
         end
         drain_results();
      end

      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
